@@ hw/rtl/gsma_pkg.sv @@
`default_nettype none

package gsma_pkg;

  // Default window depth (legal range 1..15, as sample_count is 4 bits wide)
  localparam int WINDOW_DEF = 8;

  // Input field widths
  localparam int IN_TEMP_W = 16;
  localparam int IN_HUM_W  = 16;
  localparam int IN_PRES_W = 18;
  localparam int TIME_W    = 32;

  // Stored sample and average widths
  localparam int TEMP_W    = 15;
  localparam int HUM_W     = 14;
  localparam int PRES_W    = 17;
  localparam int CNT_OUT_W = 4;
  localparam int FAIL_W    = 16;

  // Plausibility limits
  localparam logic signed [IN_TEMP_W-1:0] T_MIN = -16'sd4000;
  localparam logic signed [IN_TEMP_W-1:0] T_MAX = 16'sd8500;
  localparam logic [IN_HUM_W-1:0]         H_MAX = 16'd10000;
  localparam logic [IN_PRES_W-1:0]        P_MIN = 18'd10000;
  localparam logic [IN_PRES_W-1:0]        P_MAX = 18'd120000;

  localparam logic [TIME_W-1:0] STALE_RESET = 32'd60000;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CH_TEMP,
    CH_HUMID,
    CH_PRESS
  } chan_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0]         h;
    logic [PRES_W-1:0]        p;
  } sample_t;

endpackage

`default_nettype wire

@@ hw/rtl/gsma_ifs.sv @@
`default_nettype none

interface gsma_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       cmd;
  logic                                       link_ok;
  logic signed [gsma_pkg::IN_TEMP_W-1:0]      temperature_centi;
  logic [gsma_pkg::IN_HUM_W-1:0]              humidity_centi;
  logic [gsma_pkg::IN_PRES_W-1:0]             pressure_pa;
  logic [gsma_pkg::TIME_W-1:0]                now_ms;

  modport source (output valid, cmd, link_ok, temperature_centi, humidity_centi,
                  pressure_pa, now_ms, input ready);
  modport sink   (input valid, cmd, link_ok, temperature_centi, humidity_centi,
                  pressure_pa, now_ms, output ready);
endinterface

interface gsma_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic                                 reading_valid;
  logic signed [gsma_pkg::TEMP_W-1:0]   avg_temperature_centi;
  logic [gsma_pkg::HUM_W-1:0]           avg_humidity_centi;
  logic [gsma_pkg::PRES_W-1:0]          avg_pressure_pa;
  logic [gsma_pkg::CNT_OUT_W-1:0]       sample_count;
  logic [gsma_pkg::FAIL_W-1:0]          failure_count;
  logic                                 went_stale;

  modport source (output valid, accepted, reading_valid, avg_temperature_centi,
                  avg_humidity_centi, avg_pressure_pa, sample_count, failure_count,
                  went_stale, input ready);
  modport sink   (input valid, accepted, reading_valid, avg_temperature_centi,
                  avg_humidity_centi, avg_pressure_pa, sample_count, failure_count,
                  went_stale, output ready);
endinterface

interface gsma_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gsma_pkg::TIME_W-1:0]   stale_after_ms;

  modport source (output valid, stale_after_ms, input ready);
  modport sink   (input valid, stale_after_ms, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gated_sensor_moving_average_unit.sv @@
`default_nettype none

// Gated sensor moving average. Each input beat is a clear command or a read
// attempt; plausible samples enter a WINDOW-deep ring and the three channel
// means (truncated toward zero) come out with the fill count, the saturating
// failure count and accept/stale flags, one result beat per input beat. The
// single shared restoring divider produces one quotient bit per cycle for each
// of the three channel sums in turn, over DW = 17 + clog2(WINDOW+1) bits.
// in_ch.ready is high only while the sequencer is idle; a finished result waits
// in the output register and does not hold off the next input beat, though the
// next result waits in ST_DONE until the held one is taken. The window store is
// not cleared; the fill count guarantees that only written entries enter the sums.
module gated_sensor_moving_average_unit #(
  parameter int WINDOW = gsma_pkg::WINDOW_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  gsma_in_if.sink      in_ch,
  gsma_out_if.source   out_ch,
  gsma_cfg_if.sink     cfg_ch
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int SLW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TSW = gsma_pkg::TEMP_W + CW;
  localparam int HSW = gsma_pkg::HUM_W + CW;
  localparam int PSW = gsma_pkg::PRES_W + CW;
  localparam int DW  = PSW;
  localparam int BCW = $clog2(DW);

  gsma_pkg::state_t state_r, state_nxt;
  gsma_pkg::chan_t  ch_r;

  // latched input beat
  logic                                   cmd_r;
  logic                                   link_r;
  logic signed [gsma_pkg::IN_TEMP_W-1:0]  tin_r;
  logic [gsma_pkg::IN_HUM_W-1:0]          hin_r;
  logic [gsma_pkg::IN_PRES_W-1:0]         pin_r;
  logic [gsma_pkg::TIME_W-1:0]            now_r;

  // architectural state
  logic signed [TSW-1:0]          tsum_r, tsum_nxt;
  logic [HSW-1:0]                 hsum_r, hsum_nxt;
  logic [PSW-1:0]                 psum_r, psum_nxt;
  logic [CW-1:0]                  fill_r, fill_nxt;
  logic [SLW-1:0]                 slot_r, slot_nxt;
  logic                           valid_r, valid_nxt;
  logic [gsma_pkg::FAIL_W-1:0]    fail_r, fail_nxt;
  logic [gsma_pkg::TIME_W-1:0]    last_r, last_nxt;
  logic [gsma_pkg::TIME_W-1:0]    stale_lim_r;
  logic                           acc_r, acc_nxt;
  logic                           stale_r, stale_nxt;

  // window store
  gsma_pkg::sample_t mem [WINDOW];
  gsma_pkg::sample_t rd_r;
  gsma_pkg::sample_t wr_sample;
  logic              mem_we;

  // divider
  logic [DW-1:0]   num_r, num_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [BCW-1:0]  bit_r;
  logic            neg_r;
  logic [CW:0]     div_sh;
  logic            div_ge;
  logic signed [TSW-1:0] tsum_neg;

  // working averages and output register
  logic signed [gsma_pkg::TEMP_W-1:0] avg_t_r, out_t_r;
  logic [gsma_pkg::HUM_W-1:0]         avg_h_r, out_h_r;
  logic [gsma_pkg::PRES_W-1:0]        avg_p_r, out_p_r;
  logic                               out_valid_r;
  logic                               out_acc_r, out_rv_r, out_stale_r;
  logic [gsma_pkg::CNT_OUT_W-1:0]     out_cnt_r;
  logic [gsma_pkg::FAIL_W-1:0]        out_fail_r;

  // sequencer strobes
  logic in_fire, eval_en, load_en, div_en, store_en, done_fire;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsma_pkg::ST_IDLE:  if (in_ch.valid) state_nxt = gsma_pkg::ST_EVAL;
      gsma_pkg::ST_EVAL:  state_nxt = gsma_pkg::ST_LOAD;
      gsma_pkg::ST_LOAD:  state_nxt = gsma_pkg::ST_DIV;
      gsma_pkg::ST_DIV:   if (bit_r == '0) state_nxt = gsma_pkg::ST_STORE;
      gsma_pkg::ST_STORE: begin
        if (ch_r == gsma_pkg::CH_PRESS) state_nxt = gsma_pkg::ST_DONE;
        else state_nxt = gsma_pkg::ST_LOAD;
      end
      gsma_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = gsma_pkg::ST_IDLE;
      default:            state_nxt = gsma_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_ch.ready = 1'b0;
    eval_en     = 1'b0;
    load_en     = 1'b0;
    div_en      = 1'b0;
    store_en    = 1'b0;
    done_fire   = 1'b0;
    case (state_r)
      gsma_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      gsma_pkg::ST_EVAL:  eval_en = 1'b1;
      gsma_pkg::ST_LOAD:  load_en = 1'b1;
      gsma_pkg::ST_DIV:   div_en = 1'b1;
      gsma_pkg::ST_STORE: store_en = 1'b1;
      gsma_pkg::ST_DONE:  done_fire = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- item evaluation ----------------
  logic                        in_good;
  logic                        full;
  logic [gsma_pkg::TIME_W-1:0] age;

  always_comb begin
    in_good = (cmd_r == gsma_pkg::CMD_READ) && link_r &&
              (tin_r >= gsma_pkg::T_MIN) && (tin_r <= gsma_pkg::T_MAX) &&
              (hin_r <= gsma_pkg::H_MAX) &&
              (pin_r >= gsma_pkg::P_MIN) && (pin_r <= gsma_pkg::P_MAX);
    full    = (fill_r == CW'(WINDOW));
    age     = now_r - last_r;

    wr_sample.t = gsma_pkg::TEMP_W'(tin_r);
    wr_sample.h = gsma_pkg::HUM_W'(hin_r);
    wr_sample.p = gsma_pkg::PRES_W'(pin_r);
    mem_we      = 1'b0;

    tsum_nxt  = tsum_r;
    hsum_nxt  = hsum_r;
    psum_nxt  = psum_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    fail_nxt  = fail_r;
    last_nxt  = last_r;
    acc_nxt   = 1'b0;
    stale_nxt = 1'b0;

    if (cmd_r == gsma_pkg::CMD_CLEAR) begin
      tsum_nxt  = '0;
      hsum_nxt  = '0;
      psum_nxt  = '0;
      fill_nxt  = '0;
      slot_nxt  = '0;
      valid_nxt = 1'b0;
    end else if (in_good) begin
      mem_we = 1'b1;
      // rd_r holds the entry at slot_r, the oldest one once the ring is full
      if (full) begin
        tsum_nxt = tsum_r - TSW'(rd_r.t) + TSW'(wr_sample.t);
        hsum_nxt = hsum_r - HSW'(rd_r.h) + HSW'(wr_sample.h);
        psum_nxt = psum_r - PSW'(rd_r.p) + PSW'(wr_sample.p);
      end else begin
        tsum_nxt = tsum_r + TSW'(wr_sample.t);
        hsum_nxt = hsum_r + HSW'(wr_sample.h);
        psum_nxt = psum_r + PSW'(wr_sample.p);
        fill_nxt = fill_r + 1'b1;
      end
      slot_nxt  = (slot_r == SLW'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      last_nxt  = now_r;
      valid_nxt = 1'b1;
      acc_nxt   = 1'b1;
    end else begin
      if (fail_r != '1) fail_nxt = fail_r + 1'b1;
      if (age >= stale_lim_r) begin
        tsum_nxt  = '0;
        hsum_nxt  = '0;
        psum_nxt  = '0;
        fill_nxt  = '0;
        slot_nxt  = '0;
        valid_nxt = 1'b0;
        stale_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_ch.cmd;
      link_r <= in_ch.link_ok;
      tin_r  <= in_ch.temperature_centi;
      hin_r  <= in_ch.humidity_centi;
      pin_r  <= in_ch.pressure_pa;
      now_r  <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsum_r      <= '0;
      hsum_r      <= '0;
      psum_r      <= '0;
      fill_r      <= '0;
      slot_r      <= '0;
      valid_r     <= 1'b0;
      fail_r      <= '0;
      last_r      <= '0;
      acc_r       <= 1'b0;
      stale_r     <= 1'b0;
      stale_lim_r <= gsma_pkg::STALE_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) stale_lim_r <= cfg_ch.stale_after_ms;
      if (eval_en) begin
        tsum_r  <= tsum_nxt;
        hsum_r  <= hsum_nxt;
        psum_r  <= psum_nxt;
        fill_r  <= fill_nxt;
        slot_r  <= slot_nxt;
        valid_r <= valid_nxt;
        fail_r  <= fail_nxt;
        last_r  <= last_nxt;
        acc_r   <= acc_nxt;
        stale_r <= stale_nxt;
      end
    end
  end

  // ---------------- window store ----------------
  always_ff @(posedge clk) begin
    if (mem_we && eval_en) mem[slot_r] <= wr_sample;
    rd_r <= mem[slot_r];
  end

  // ---------------- shared restoring divider ----------------
  assign tsum_neg = -tsum_r;
  assign div_sh   = {rem_r, num_r[DW-1]};
  assign div_ge   = (div_sh >= {1'b0, fill_r});

  always_comb begin
    rem_nxt = div_ge ? CW'(div_sh - {1'b0, fill_r}) : CW'(div_sh);
    num_nxt = {num_r[DW-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= gsma_pkg::CH_TEMP;
    end else if (eval_en) begin
      ch_r <= gsma_pkg::CH_TEMP;
    end else if (store_en) begin
      case (ch_r)
        gsma_pkg::CH_TEMP:  ch_r <= gsma_pkg::CH_HUMID;
        gsma_pkg::CH_HUMID: ch_r <= gsma_pkg::CH_PRESS;
        default:            ch_r <= gsma_pkg::CH_TEMP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      rem_r <= '0;
      bit_r <= BCW'(DW - 1);
      case (ch_r)
        gsma_pkg::CH_TEMP: begin
          num_r <= DW'($unsigned(tsum_r[TSW-1] ? tsum_neg : tsum_r));
          neg_r <= tsum_r[TSW-1];
        end
        gsma_pkg::CH_HUMID: begin
          num_r <= DW'(hsum_r);
          neg_r <= 1'b0;
        end
        default: begin
          num_r <= DW'(psum_r);
          neg_r <= 1'b0;
        end
      endcase
    end else if (div_en) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      bit_r <= bit_r - 1'b1;
    end
  end

  // an empty window reads as zero averages
  always_ff @(posedge clk) begin
    if (store_en) begin
      case (ch_r)
        gsma_pkg::CH_TEMP: begin
          if (fill_r == '0) avg_t_r <= '0;
          else if (neg_r) avg_t_r <= -gsma_pkg::TEMP_W'(num_r);
          else avg_t_r <= gsma_pkg::TEMP_W'(num_r);
        end
        gsma_pkg::CH_HUMID: avg_h_r <= (fill_r == '0) ? '0 : gsma_pkg::HUM_W'(num_r);
        default:            avg_p_r <= (fill_r == '0) ? '0 : gsma_pkg::PRES_W'(num_r);
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_acc_r   <= acc_r;
      out_rv_r    <= valid_r;
      out_t_r     <= avg_t_r;
      out_h_r     <= avg_h_r;
      out_p_r     <= avg_p_r;
      out_cnt_r   <= gsma_pkg::CNT_OUT_W'(fill_r);
      out_fail_r  <= fail_r;
      out_stale_r <= stale_r;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.accepted              = out_acc_r;
  assign out_ch.reading_valid         = out_rv_r;
  assign out_ch.avg_temperature_centi = out_t_r;
  assign out_ch.avg_humidity_centi    = out_h_r;
  assign out_ch.avg_pressure_pa       = out_p_r;
  assign out_ch.sample_count          = out_cnt_r;
  assign out_ch.failure_count         = out_fail_r;
  assign out_ch.went_stale            = out_stale_r;

endmodule

`default_nettype wire

@@ hw/rtl/gsma_checker.sv @@
`default_nettype none

module gsma_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_ready,
  input wire                                  out_valid,
  input wire                                  out_ready,
  input wire                                  out_accepted,
  input wire                                  out_reading_valid,
  input wire signed [gsma_pkg::TEMP_W-1:0]    out_avg_t,
  input wire [gsma_pkg::HUM_W-1:0]            out_avg_h,
  input wire [gsma_pkg::PRES_W-1:0]           out_avg_p,
  input wire [gsma_pkg::CNT_OUT_W-1:0]        out_count,
  input wire                                  out_went_stale
);

  // one item at a time: an accepted beat drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  a_accept_excl_stale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_reading_valid && !out_went_stale)
    else $error("accepted result without valid reading or with stale flag");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reading_valid |->
      out_count == '0 && out_avg_t == '0 && out_avg_h == '0 && out_avg_p == '0)
    else $error("empty window reports nonzero averages or count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_avg_p) && $stable(out_count))
    else $error("stalled result beat changed");

endmodule

bind gated_sensor_moving_average_unit gsma_checker u_gsma_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_accepted      (out_ch.accepted),
  .out_reading_valid (out_ch.reading_valid),
  .out_avg_t         (out_ch.avg_temperature_centi),
  .out_avg_h         (out_ch.avg_humidity_centi),
  .out_avg_p         (out_ch.avg_pressure_pa),
  .out_count         (out_ch.sample_count),
  .out_went_stale    (out_ch.went_stale)
);

`default_nettype wire
